/* hw/rtl/etd_pkg.sv */
`timescale 1ns / 1ps

package etd_pkg;

    localparam int HR_W    = 8;
    localparam int PWR_W   = 11;
    localparam int LEVEL_W = 12;
    localparam int WAIT_W  = 16;
    localparam int CFG_W   = 11;

    // Config register indexes
    localparam logic CFG_MAX_HR  = 1'b0;
    localparam logic CFG_THR_PWR = 1'b1;

    localparam logic [HR_W-1:0]  MAX_HR_RST  = 8'd190;
    localparam logic [PWR_W-1:0] THR_PWR_RST = 11'd250;

    localparam int TICKS_PER_SECOND_DEF = 1000000;
    localparam int TPS_W = 27;   // holds the top of the tick-rate range

    // Fixed pipeline depths of the two submodules
    localparam int DIV_LAT  = 6;
    localparam int WAIT_LAT = 22;

    // Delay polynomial, units of 1e-8 s, highest order first
    localparam logic signed [24:0] POLY_C [5] = '{
        -25'sd5682765, 25'sd12686553, -25'sd10213589, 25'sd2949355, 25'sd262442
    };

    typedef struct packed {
        logic [HR_W-1:0]  heart_rate;
        logic [PWR_W-1:0] power_watts;
    } t_in_req;

    typedef struct packed {
        logic [WAIT_W-1:0]  trigger_wait;
        logic [LEVEL_W-1:0] heart_level;
        logic [LEVEL_W-1:0] power_level;
        logic [LEVEL_W-1:0] driving_level;
    } t_out_req;

endpackage

/* hw/rtl/etd_div.sv */
`timescale 1ns / 1ps

// floor(x*1024/d) saturating at 4095; two quotient bits per stage
module etd_div #(
    parameter int XW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_x,
    input  logic [DW-1:0] i_d,
    output logic [11:0]   o_level
);

    localparam int MW = (XW > DW) ? XW : DW;
    localparam int RW = MW + 11;
    localparam int NS = 6;

    logic [RW-1:0] r_rem [0:NS-2];
    logic [11:0]   r_q   [0:NS-1];
    logic [DW-1:0] r_d   [0:NS-2];
    logic          r_sat [0:NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [RW-1:0] rem_in, rem_a, rem_b, dv_a, dv_b;
        logic [11:0]   q_in, q_b;
        logic [DW-1:0] d_in;
        logic          sat_in;

        if (k == 0) begin : g_first
            assign rem_in = RW'(i_x) << 10;
            assign q_in   = '0;
            assign d_in   = i_d;
            // quotient >= 4096 exactly when x >= 4*d (covers d == 0)
            assign sat_in = (MW+2)'(i_x) >= ((MW+2)'(i_d) << 2);
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign d_in   = r_d[k-1];
            assign sat_in = r_sat[k-1];
        end

        always_comb begin
            dv_a  = RW'(d_in) << (11 - 2*k);
            dv_b  = RW'(d_in) << (10 - 2*k);
            q_b   = q_in;
            rem_a = rem_in;
            if (rem_in >= dv_a) begin
                rem_a         = rem_in - dv_a;
                q_b[11 - 2*k] = 1'b1;
            end
            rem_b = rem_a;
            if (rem_a >= dv_b) begin
                rem_b         = rem_a - dv_b;
                q_b[10 - 2*k] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= q_b;
                r_sat[k] <= sat_in;
            end
        end

        if (k < NS-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= rem_b;
                    r_d[k]   <= d_in;
                end
            end
        end
    end

    assign o_level = r_sat[NS-1] ? 12'hFFF : r_q[NS-1];

endmodule

/* hw/rtl/etd_wait.sv */
`timescale 1ns / 1ps

// Driving level -> triac wait in ticks. Fixed 22-stage pipeline.
module etd_wait #(
    parameter int TICKS_PER_SECOND = etd_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [11:0] i_level,
    output logic [15:0] o_wait
);

    localparam logic [63:0] LOW_RAW =
        (64'd526 * 64'(TICKS_PER_SECOND) + 64'd50000) / 64'd100000;
    localparam logic [15:0] LOW_WAIT = (LOW_RAW > 64'd65535) ? 16'hFFFF : LOW_RAW[15:0];

    localparam logic [etd_pkg::TPS_W-1:0] TPS_V = etd_pkg::TPS_W'(TICKS_PER_SECOND);

    // 1e8 * 2^16 divisor, its half, and the saturation bound 65536 * divisor
    localparam logic [58:0] DIV_C  = 59'd6553600000000;
    localparam logic [68:0] HALF_C = 69'd3276800000000;
    localparam logic [68:0] LIMIT  = 69'd429496729600000000;

    localparam logic signed [41:0] ACC0 = 42'(etd_pkg::POLY_C[0]) <<< 16;

    // 1/15 as 2^24 reciprocal, exact for 20-bit numerators
    localparam logic [20:0] RECIP15 = 21'd1118482;

    localparam int NF = 21;  // flag stages before the final register

    logic               r_lo   [0:NF-1];
    logic               r_hi   [0:NF-1];
    logic [19:0]        r_v;
    logic [40:0]        r_prod;
    logic [15:0]        r_sd   [0:6];
    logic signed [34:0] r_ph   [0:3];
    logic [39:0]        r_pl   [0:3];
    logic signed [41:0] r_acc  [0:3];
    logic [46:0]        r_mh;
    logic [47:0]        r_ml;
    logic [58:0]        r_n;
    logic               r_nsat;
    logic [58:0]        r_dr   [0:6];
    logic [15:0]        r_dq   [0:7];
    logic               r_dsat [0:7];
    logic [15:0]        r_wait;

    logic [17:0] t35, tsub;
    logic [40:0] accc;
    logic [68:0] n_full;

    always_comb begin
        t35  = 18'(i_level) * 18'd35;
        tsub = t35 - 18'd13312;
        accc = r_acc[3][41] ? '0 : r_acc[3][40:0];
        n_full = (69'(r_mh) << 21) + 69'(r_ml) + HALF_C;
    end

    // Front: scale, reciprocal multiply, S; clamp and tick conversion
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo[0] <= i_level < 12'd512;
            r_hi[0] <= i_level > 12'd819;
            for (int m = 1; m < NF; m++) begin
                r_lo[m] <= r_lo[m-1];
                r_hi[m] <= r_hi[m-1];
            end
            r_v    <= {tsub[13:0], 6'd7};
            r_prod <= 41'(r_v) * 41'(RECIP15);
            r_sd[0] <= r_prod[39:24];
            for (int m = 1; m < 7; m++) begin
                r_sd[m] <= r_sd[m-1];
            end
            r_mh   <= 47'(accc[40:21]) * 47'(TPS_V);
            r_ml   <= 48'(accc[20:0]) * 48'(TPS_V);
            r_n    <= n_full[58:0];
            r_nsat <= n_full >= LIMIT;
        end
    end

    // Horner steps: partial products, then combine, round, add coefficient
    for (genvar h = 0; h < 4; h++) begin : g_horn
        logic signed [41:0] acc_in;
        logic signed [59:0] sum;
        logic signed [43:0] sum_sh;

        if (h == 0) begin : g_c
            assign acc_in = ACC0;
        end else begin : g_r
            assign acc_in = r_acc[h-1];
        end

        always_comb begin
            sum    = (60'(r_ph[h]) <<< 24) + $signed(60'(r_pl[h])) + 60'sd32768;
            sum_sh = 44'(sum >>> 16);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ph[h]  <= 35'($signed(acc_in[41:24])) *
                            35'($signed({1'b0, r_sd[2*h]}));
                r_pl[h]  <= 40'(acc_in[23:0]) * 40'(r_sd[2*h]);
                r_acc[h] <= 42'(sum_sh) + (42'(etd_pkg::POLY_C[h+1]) <<< 16);
            end
        end
    end

    // Division by 1e8*2^16, two quotient bits per stage
    for (genvar j = 0; j < 8; j++) begin : g_dv
        logic [58:0] rem_in, rem_a, rem_b;
        logic [15:0] q_in, q_b;
        logic        sat_in;

        if (j == 0) begin : g_f
            assign rem_in = r_n;
            assign q_in   = '0;
            assign sat_in = r_nsat;
        end else begin : g_n
            assign rem_in = r_dr[j-1];
            assign q_in   = r_dq[j-1];
            assign sat_in = r_dsat[j-1];
        end

        always_comb begin
            q_b   = q_in;
            rem_a = rem_in;
            if (rem_in >= (DIV_C << (15 - 2*j))) begin
                rem_a         = rem_in - (DIV_C << (15 - 2*j));
                q_b[15 - 2*j] = 1'b1;
            end
            rem_b = rem_a;
            if (rem_a >= (DIV_C << (14 - 2*j))) begin
                rem_b         = rem_a - (DIV_C << (14 - 2*j));
                q_b[14 - 2*j] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[j]   <= q_b;
                r_dsat[j] <= sat_in;
            end
        end

        if (j < 7) begin : g_c
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dr[j] <= rem_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_lo[NF-1]) begin
                r_wait <= LOW_WAIT;
            end else if (r_hi[NF-1]) begin
                r_wait <= '0;
            end else if (r_dsat[7]) begin
                r_wait <= 16'hFFFF;
            end else begin
                r_wait <= r_dq[7];
            end
        end
    end

    assign o_wait = r_wait;

endmodule

/* hw/rtl/effort_to_triac_delay_top.sv */
`timescale 1ns / 1ps

// Throughput: one request per cycle; the pipeline moves as a whole and holds while
// a finished result sits stalled in the output register.
// Reset (i_rst_n low at a clock edge): all stage valid bits clear, max_heart_rate
// returns to 190 and threshold_power to 250.
module effort_to_triac_delay_top #(
    parameter int TICKS_PER_SECOND = etd_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [etd_pkg::CFG_W-1:0]     i_cfg_data,
    // request in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  etd_pkg::t_in_req              i_in,
    // result out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output etd_pkg::t_out_req             o_out
);

    // Stage map: input reg (1), level dividers (6), max select (1),
    // wait pipeline (22), output reg (1).
    localparam int NV = 1 + etd_pkg::DIV_LAT + 1 + etd_pkg::WAIT_LAT;

    typedef struct packed {
        logic [etd_pkg::LEVEL_W-1:0] hl;
        logic [etd_pkg::LEVEL_W-1:0] pl;
        logic [etd_pkg::LEVEL_W-1:0] dl;
    } t_lvl;

    logic [etd_pkg::HR_W-1:0]  r_max_hr;
    logic [etd_pkg::PWR_W-1:0] r_thr_pwr;

    logic               r_vld [0:NV-1];
    etd_pkg::t_in_req   r_in;
    t_lvl               r_lvl;
    t_lvl               r_lvl_dly [0:etd_pkg::WAIT_LAT-1];
    logic               r_out_valid;
    etd_pkg::t_out_req  r_out;

    logic                        en;
    logic [etd_pkg::LEVEL_W-1:0] hl, pl;
    logic [etd_pkg::WAIT_W-1:0]  wait_ticks;

    // Whole pipeline advances unless the output holds a stalled result.
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // Config registers; the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hr  <= etd_pkg::MAX_HR_RST;
            r_thr_pwr <= etd_pkg::THR_PWR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                etd_pkg::CFG_MAX_HR:  r_max_hr  <= i_cfg_data[etd_pkg::HR_W-1:0];
                etd_pkg::CFG_THR_PWR: r_thr_pwr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NV; m++) begin
                r_vld[m] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int m = 1; m < NV; m++) begin
                r_vld[m] <= r_vld[m-1];
            end
            r_out_valid <= r_vld[NV-1];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in;
        end
    end

    // Effort fractions, Q2.10, saturating
    etd_div #(.XW(etd_pkg::HR_W), .DW(etd_pkg::HR_W)) u_div_hr (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_in.heart_rate),
        .i_d     (r_max_hr),
        .o_level (hl)
    );

    etd_div #(.XW(etd_pkg::PWR_W), .DW(etd_pkg::PWR_W)) u_div_pwr (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_in.power_watts),
        .i_d     (r_thr_pwr),
        .o_level (pl)
    );

    // Larger fraction drives the fan; levels wait alongside the delay math.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lvl.hl <= hl;
            r_lvl.pl <= pl;
            r_lvl.dl <= (hl > pl) ? hl : pl;
            r_lvl_dly[0] <= r_lvl;
            for (int m = 1; m < etd_pkg::WAIT_LAT; m++) begin
                r_lvl_dly[m] <= r_lvl_dly[m-1];
            end
        end
    end

    // Region select, quartic Horner evaluation, seconds -> ticks
    etd_wait #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_wait (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_level (r_lvl.dl),
        .o_wait  (wait_ticks)
    );

    // Output register parts the pipeline from the consumer.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.trigger_wait  <= wait_ticks;
            r_out.heart_level   <= r_lvl_dly[etd_pkg::WAIT_LAT-1].hl;
            r_out.power_level   <= r_lvl_dly[etd_pkg::WAIT_LAT-1].pl;
            r_out.driving_level <= r_lvl_dly[etd_pkg::WAIT_LAT-1].dl;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import etd_pkg::*;

    localparam longint TPS       = TICKS_PER_SECOND_DEF;
    localparam int     DRAIN_CYC = 40;           // pipeline latency plus margin
    localparam int     CYCLE_CAP = 2_000_000;

    // -------------------------------------------------------------------
    // Expected-result store: computes fan drive from effort, holds the
    // pending results in request order and checks each one on arrival.
    // -------------------------------------------------------------------
    class fan_drive_board;
        t_out_req pending[$];
        int       fails;
        int       hr_max;
        int       pwr_thr;
        longint   coef[5] = '{-5682765, 12686553, -10213589, 2949355, 262442};

        function new();
            fails   = 0;
            hr_max  = int'(MAX_HR_RST);
            pwr_thr = int'(THR_PWR_RST);
        endfunction

        function int level(int x, int d);
            int q;
            if (d == 0) return 4095;
            q = (x * 1024) / d;
            return (q > 4095) ? 4095 : q;
        endfunction

        // Horner evaluation in Q16, coefficients in units of 1e-8 s
        function longint curve_wait(int d);
            longint s, acc, t;
            s   = ((35 * d - 13312) * 64 + 7) / 15;
            acc = coef[0] * 65536;
            for (int i = 1; i < 5; i++)
                acc = ((acc * s + 32768) >>> 16) + coef[i] * 65536;
            if (acc < 0) acc = 0;
            t = (acc * TPS + 64'd100000000 * 32768) / (64'd100000000 * 65536);
            return (t > 65535) ? 65535 : t;
        endfunction

        function void note_request(t_in_req r);
            t_out_req e;
            int hl, pl, dl;
            longint w;
            hl = level(int'(r.heart_rate), hr_max);
            pl = level(int'(r.power_watts), pwr_thr);
            dl = (hl > pl) ? hl : pl;
            if (dl < 512) begin
                w = (526 * TPS + 50000) / 100000;
                if (w > 65535) w = 65535;
            end else if (dl > 819) begin
                w = 0;
            end else begin
                w = curve_wait(dl);
            end
            e.trigger_wait  = w[15:0];
            e.heart_level   = hl[11:0];
            e.power_level   = pl[11:0];
            e.driving_level = dl[11:0];
            pending.push_back(e);
        endfunction

        function void check_result(t_out_req got);
            t_out_req e;
            if (pending.size() == 0) begin
                $error("unexpected result request %h", got);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (got.trigger_wait !== e.trigger_wait) begin
                $error("trigger_wait exp %0d got %0d", e.trigger_wait, got.trigger_wait);
                fails++;
            end
            if (got.heart_level !== e.heart_level) begin
                $error("heart_level exp %0d got %0d", e.heart_level, got.heart_level);
                fails++;
            end
            if (got.power_level !== e.power_level) begin
                $error("power_level exp %0d got %0d", e.power_level, got.power_level);
                fails++;
            end
            if (got.driving_level !== e.driving_level) begin
                $error("driving_level exp %0d got %0d", e.driving_level, got.driving_level);
                fails++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_req          i_in;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_req         o_out;

    fan_drive_board board = new();
    int  cycle_count = 0;
    bit  no_gaps = 0;         // when set, sender runs back to back

    effort_to_triac_delay_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitors: both handshakes sampled at the edge, before the drivers' updates land.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_in_valid && !o_in_stall)
            board.note_request(i_in);
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_out);
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall before each result, some stretches with none.
    initial begin
        int n;
        i_out_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Register write, only while the block is idle.
    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MAX_HR) board.hr_max = int'(val[HR_W-1:0]);
        else                   board.pwr_thr = int'(val);
    endtask

    // Send one request after a random gap, or none when no_gaps is set; returns after it is accepted.
    task automatic send_request(int hr, int pw);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_in.heart_rate   <= hr[HR_W-1:0];
        i_in.power_watts  <= pw[PWR_W-1:0];
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait for every pending result, plus pipeline latency.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Random request aimed mostly around the half..0.8 band of one input.
    task automatic random_request();
        int hr, pw, pick;
        pick = $urandom_range(0, 2);
        hr = $urandom_range(0, 255);
        pw = $urandom_range(0, 2047);
        if (pick == 1) begin
            hr = (board.hr_max * $urandom_range(400, 900)) / 1000;
            pw = (board.pwr_thr * $urandom_range(0, 800)) / 1000;
        end else if (pick == 2) begin
            pw = (board.pwr_thr * $urandom_range(400, 900)) / 1000;
            hr = (board.hr_max * $urandom_range(0, 800)) / 1000;
        end
        if (hr > 255)  hr = 255;
        if (pw > 2047) pw = 2047;
        send_request(hr, pw);
    endtask

    initial begin
        int hr_set[5] = '{190, 1, 255, 0, 150};
        int pw_set[5] = '{250, 1, 2047, 0, 300};

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_MAX_HR;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset settings: extremes, low/mid/high bands and the edges
        // of the mid band (D = 512 at hr 95, D = 819 at hr 152 and at pw 200).
        send_request(0, 0);
        send_request(255, 2047);
        send_request(255, 0);
        send_request(0, 2047);
        send_request(95, 0);
        send_request(94, 0);
        send_request(151, 0);
        send_request(152, 0);
        send_request(0, 125);
        send_request(0, 200);
        send_request(0, 201);
        send_request(120, 170);
        send_request(170, 120);
        send_request(8'haa, 11'h555);
        send_request(8'h55, 11'h2aa);
        drain();

        // Zero divisors, and upper bits of a heart-rate write that must be dropped
        write_reg(CFG_MAX_HR, 11'h700);
        write_reg(CFG_THR_PWR, 11'd0);
        send_request(0, 0);
        send_request(255, 2047);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_MAX_HR, {3'($urandom_range(0, 7)), 8'(hr_set[ph])});
            write_reg(CFG_THR_PWR, 11'(pw_set[ph]));
            for (int k = 0; k < 320; k++) begin
                no_gaps = (k >= 100 && k < 140);
                random_request();
                // hold off once per phase until the pipeline is empty
                if (k == 200) drain();
            end
            no_gaps = 0;
            drain();
        end

        if (board.fails == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
